// ===== hdl/bit_vector_rank_select_unit_macros.svh =====
// Assertion macros used by the RTL datapath (bvrs_dp).
`ifndef BIT_VECTOR_RANK_SELECT_UNIT_MACROS_SVH
`define BIT_VECTOR_RANK_SELECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BVRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BVRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BVRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BVRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/bvrs_pkg.sv =====
package bvrs_pkg;

  localparam int MAX_BITS = 4096;
  localparam int TAB_DEPTH = MAX_BITS + 1;
  localparam int ADDR_W = $clog2(TAB_DEPTH);
  localparam int FIELD_W = 13;
  localparam int CMD_W = 3;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_ACCESS = 3'd2,
    CMD_RANK   = 3'd3,
    CMD_SELECT = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } st_code_t;

  typedef enum logic [1:0] {
    RD_POS_IN,
    RD_POS_NEXT,
    RD_MID
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FULL,
    RES_RANGE,
    RES_ABSENT,
    RES_ACCESS,
    RES_RANK,
    RES_SELECT
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC1,
    S_ACC2,
    S_RANK1,
    S_SEL_CHK,
    S_SEL_CMP
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     clear;
    logic     append;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_a;
    logic     search_init;
    logic     search_step;
    logic     done;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      full;
    logic      access_bad;
    logic      rank_bad;
    logic      ord_bad;
    logic      search_more;
    logic      out_free;
  } dp_stat_t;

endpackage

// ===== hdl/bvrs_ram.sv =====
module bvrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bvrs_ctrl.sv =====
module bvrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bvrs_pkg::dp_stat_t stat,
  output bvrs_pkg::dp_cmd_t  cmd
);

  bvrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bvrs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.rd_sel  = bvrs_pkg::RD_POS_IN;
    cmd.res_sel = bvrs_pkg::RES_ZERO;
    unique case (state_r)
      bvrs_pkg::S_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          cmd.latch = 1'b1;
          case (stat.cmd)
            bvrs_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.done  = 1'b1;
            end
            bvrs_pkg::CMD_APPEND: begin
              cmd.done = 1'b1;
              if (stat.full) begin
                cmd.res_sel = bvrs_pkg::RES_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            bvrs_pkg::CMD_ACCESS: begin
              if (stat.access_bad) begin
                cmd.done    = 1'b1;
                cmd.res_sel = bvrs_pkg::RES_RANGE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = bvrs_pkg::S_ACC1;
              end
            end
            bvrs_pkg::CMD_RANK: begin
              if (stat.rank_bad) begin
                cmd.done    = 1'b1;
                cmd.res_sel = bvrs_pkg::RES_RANGE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = bvrs_pkg::S_RANK1;
              end
            end
            bvrs_pkg::CMD_SELECT: begin
              if (stat.ord_bad) begin
                cmd.done    = 1'b1;
                cmd.res_sel = bvrs_pkg::RES_ABSENT;
              end else begin
                cmd.search_init = 1'b1;
                state_nxt       = bvrs_pkg::S_SEL_CHK;
              end
            end
            default: begin
              cmd.done = 1'b1;
            end
          endcase
        end
      end
      bvrs_pkg::S_ACC1: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bvrs_pkg::RD_POS_NEXT;
        state_nxt  = bvrs_pkg::S_ACC2;
      end
      bvrs_pkg::S_ACC2: begin
        cmd.done    = 1'b1;
        cmd.res_sel = bvrs_pkg::RES_ACCESS;
        state_nxt   = bvrs_pkg::S_IDLE;
      end
      bvrs_pkg::S_RANK1: begin
        cmd.done    = 1'b1;
        cmd.res_sel = bvrs_pkg::RES_RANK;
        state_nxt   = bvrs_pkg::S_IDLE;
      end
      bvrs_pkg::S_SEL_CHK: begin
        if (stat.search_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bvrs_pkg::RD_MID;
          state_nxt  = bvrs_pkg::S_SEL_CMP;
        end else begin
          cmd.done    = 1'b1;
          cmd.res_sel = bvrs_pkg::RES_SELECT;
          state_nxt   = bvrs_pkg::S_IDLE;
        end
      end
      bvrs_pkg::S_SEL_CMP: begin
        cmd.search_step = 1'b1;
        state_nxt       = bvrs_pkg::S_SEL_CHK;
      end
      default: begin
        state_nxt = bvrs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bvrs_dp.sv =====
`include "bit_vector_rank_select_unit_macros.svh"

module bvrs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bvrs_pkg::CMD_W-1:0]          in_command,
  input  logic                                in_bit_value,
  input  logic [bvrs_pkg::FIELD_W-1:0]        in_position,
  input  logic [bvrs_pkg::FIELD_W-1:0]        in_ordinal,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [bvrs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  bvrs_pkg::dp_cmd_t                   cmd,
  output bvrs_pkg::dp_stat_t                  stat
);

  localparam logic [bvrs_pkg::FIELD_W-1:0] LEN_MAX = bvrs_pkg::FIELD_W'(bvrs_pkg::MAX_BITS);

  logic [bvrs_pkg::FIELD_W-1:0] len_r, len_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] ones_r, ones_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] pos_r, pos_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] ord_r, ord_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] lo_r, lo_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] hi_r, hi_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] mid_r, mid_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] a_r, a_nxt;
  logic                         rd_zero_r, rd_zero_nxt;
  logic [bvrs_pkg::FIELD_W-1:0] res_value_r, res_value_nxt;
  bvrs_pkg::st_code_t           res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [bvrs_pkg::FIELD_W:0]   mid_sum;
  logic [bvrs_pkg::FIELD_W-1:0] mid_c;
  logic [bvrs_pkg::FIELD_W-1:0] span;
  logic [bvrs_pkg::ADDR_W-1:0]  rd_addr;
  logic [bvrs_pkg::ADDR_W-1:0]  wr_addr;
  logic [bvrs_pkg::FIELD_W-1:0] wr_data;
  logic [bvrs_pkg::FIELD_W-1:0] ram_rdata;
  logic [bvrs_pkg::FIELD_W-1:0] rdata;

  assign mid_sum = {1'b0, hi_r} + {1'b0, lo_r};
  assign mid_c   = bvrs_pkg::FIELD_W'(mid_sum >> 1);
  assign span    = hi_r - lo_r;
  assign wr_addr = bvrs_pkg::ADDR_W'(len_r + 1'b1);
  assign wr_data = ones_r + bvrs_pkg::FIELD_W'(in_bit_value);
  assign rdata   = rd_zero_r ? '0 : ram_rdata;

  always_comb begin
    rd_addr = bvrs_pkg::ADDR_W'(in_position);
    case (cmd.rd_sel)
      bvrs_pkg::RD_POS_IN:   rd_addr = bvrs_pkg::ADDR_W'(in_position);
      bvrs_pkg::RD_POS_NEXT: rd_addr = bvrs_pkg::ADDR_W'(pos_r + 1'b1);
      bvrs_pkg::RD_MID:      rd_addr = bvrs_pkg::ADDR_W'(mid_c);
      default:               rd_addr = bvrs_pkg::ADDR_W'(in_position);
    endcase
  end

  always_comb begin
    stat.cmd         = bvrs_pkg::cmd_code_t'(in_command);
    stat.full        = (len_r == LEN_MAX);
    stat.access_bad  = (in_position >= len_r);
    stat.rank_bad    = (in_position > len_r);
    stat.ord_bad     = (in_ordinal == '0) || (in_ordinal > ones_r);
    stat.search_more = (span > bvrs_pkg::FIELD_W'(1));
    stat.out_free    = !out_valid_r || out_tready;
  end

  always_comb begin
    len_nxt        = len_r;
    ones_nxt       = ones_r;
    pos_nxt        = pos_r;
    ord_nxt        = ord_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    a_nxt          = a_r;
    rd_zero_nxt    = rd_zero_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (cmd.latch) begin
      pos_nxt = in_position;
      ord_nxt = in_ordinal;
    end
    if (cmd.clear) begin
      len_nxt  = '0;
      ones_nxt = '0;
    end
    if (cmd.append) begin
      len_nxt  = len_r + 1'b1;
      ones_nxt = wr_data;
    end
    if (cmd.rd_en) begin
      rd_zero_nxt = (rd_addr == '0);
      mid_nxt     = mid_c;
    end
    if (cmd.cap_a) begin
      a_nxt = rdata;
    end
    if (cmd.search_init) begin
      lo_nxt = '0;
      hi_nxt = len_r;
    end
    if (cmd.search_step) begin
      if (rdata >= ord_r) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r;
      end
    end
    if (cmd.done) begin
      out_valid_nxt  = 1'b1;
      res_value_nxt  = '0;
      res_status_nxt = bvrs_pkg::ST_OK;
      case (cmd.res_sel)
        bvrs_pkg::RES_FULL:   res_status_nxt = bvrs_pkg::ST_FULL;
        bvrs_pkg::RES_RANGE:  res_status_nxt = bvrs_pkg::ST_RANGE;
        bvrs_pkg::RES_ABSENT: res_status_nxt = bvrs_pkg::ST_ABSENT;
        bvrs_pkg::RES_ACCESS: res_value_nxt = rdata - a_r;
        bvrs_pkg::RES_RANK:   res_value_nxt = rdata;
        bvrs_pkg::RES_SELECT: res_value_nxt = hi_r;
        default:              res_value_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ones_r      <= '0;
      out_valid_r <= 1'b0;
      rd_zero_r   <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ones_r      <= ones_nxt;
      out_valid_r <= out_valid_nxt;
      rd_zero_r   <= rd_zero_nxt;
    end
    pos_r        <= pos_nxt;
    ord_r        <= ord_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    a_r          <= a_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  bvrs_ram #(
    .WIDTH(bvrs_pkg::FIELD_W),
    .DEPTH(bvrs_pkg::TAB_DEPTH)
  ) u_prefix_ram (
    .clk    (clk),
    .wr_en  (cmd.append),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_status_r, res_value_r};

  `BVRS_ASSERT_IMPLY(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_MAX)
  `BVRS_ASSERT_IMPLY(a_ones_le_len, clk, rst_n, 1'b1, ones_r <= len_r)
  `BVRS_ASSERT_IMPLY(a_mid_inside, clk, rst_n, cmd.search_step, (mid_r > lo_r) && (mid_r < hi_r))
  `BVRS_ASSERT_NEXT(a_done_valid, clk, rst_n, cmd.done, out_valid_r)

endmodule

// ===== hdl/bit_vector_rank_select_unit.sv =====
// Bit vector with rank and select over a prefix-count memory of MAX_BITS+1 entries, one
// write and one registered read port. One transaction in gives one result transaction out.
// Clear, append, errors and unused codes finish from the idle state; rank takes one read of
// the prefix memory, access two; select runs a binary search, each step being one read of
// the memory port and one compare. Entry zero is held as a constant zero, so no clearing
// pass runs after reset. A new command is taken once the previous result has been loaded
// into the output register and that register is empty or being read out.
module bit_vector_rank_select_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bvrs_pkg::IN_DATA_W-1:0]    in_tdata,  // bit_value, position, ordinal
  input  logic [bvrs_pkg::CMD_W-1:0]        in_tuser,  // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bvrs_pkg::OUT_DATA_W-1:0]   out_tdata  // result_value, status
);

  bvrs_pkg::dp_cmd_t  cmd;
  bvrs_pkg::dp_stat_t stat;

  bvrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bvrs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_command  (in_tuser),
    .in_bit_value(in_tdata[0]),
    .in_position (in_tdata[13:1]),
    .in_ordinal  (in_tdata[26:14]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== bench/bit_vector_rank_select_unit_tb.sv =====
module bit_vector_rank_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvrs_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PAD_W = IN_DATA_W - 1 - 2 * FIELD_W;
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    st_code_t           st;
  } answer_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               bitv;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] ord;
    logic               fixed;
    answer_t            ans;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // bit_value, position, ordinal
  logic [CMD_W-1:0]      in_tuser = '0;   // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // result_value, status

  logic [FIELD_W-1:0] prefix_count [0:MAX_BITS];
  int unsigned        vec_len;
  int unsigned        vec_ones;
  answer_t            pending_results [$];
  int                 fault_count = 0;
  bit                 calm = 1'b0;
  stim_row_t          dir_rows [0:25];

  bit_vector_rank_select_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic answer_t rank_select_predict(input logic [CMD_W-1:0] cmd,
                                                  input logic bitv,
                                                  input logic [FIELD_W-1:0] pos,
                                                  input logic [FIELD_W-1:0] ord);
    answer_t     ans;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    ans = '{value: '0, st: ST_OK};
    case (cmd)
      CMD_CLEAR: begin
        vec_len = 0;
        vec_ones = 0;
        prefix_count[0] = '0;
      end
      CMD_APPEND: begin
        if (vec_len >= MAX_BITS) begin
          ans.st = ST_FULL;
        end else begin
          prefix_count[vec_len + 1] = prefix_count[vec_len] + bitv;
          vec_len++;
          vec_ones += bitv;
        end
      end
      CMD_ACCESS: begin
        if (pos >= vec_len) ans.st = ST_RANGE;
        else ans.value = prefix_count[pos + 1] - prefix_count[pos];
      end
      CMD_RANK: begin
        if (pos > vec_len) ans.st = ST_RANGE;
        else ans.value = prefix_count[pos];
      end
      CMD_SELECT: begin
        if (ord == 0 || ord > vec_ones) begin
          ans.st = ST_ABSENT;
        end else begin
          lo = 0;
          hi = vec_len;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (prefix_count[mid] >= ord) hi = mid;
            else lo = mid;
          end
          ans.value = hi;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1));
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic bitv,
                           input logic [FIELD_W-1:0] pos, input logic [FIELD_W-1:0] ord,
                           input logic fixed = 1'b0, input answer_t fixed_ans = '0);
    int      gap;
    answer_t ans;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{PAD_W{1'b0}}, ord, pos, bitv};
    do @(posedge clk); while (!in_tready);
    ans = rank_select_predict(cmd, bitv, pos, ord);
    pending_results.push_back(fixed ? fixed_ans : ans);
  endtask

  task automatic send_random_item();
    int unsigned r;
    logic        bitv;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] ord;
    bitv = 1'($urandom_range(0, 1));
    pos  = rand_field();
    ord  = rand_field();
    r    = $urandom_range(0, 99);
    if (r < 2) begin
      send_item(CMD_CLEAR, bitv, pos, ord);
    end else if (r < 36) begin
      send_item(CMD_APPEND, bitv, pos, ord);
    end else if (r < 50 && vec_len > 0) begin
      send_item(CMD_ACCESS, bitv, FIELD_W'($urandom_range(0, vec_len - 1)), ord);
    end else if (r < 65) begin
      send_item(CMD_RANK, bitv, FIELD_W'($urandom_range(0, vec_len)), ord);
    end else if (r < 82 && vec_ones > 0) begin
      send_item(CMD_SELECT, bitv, pos, FIELD_W'($urandom_range(1, vec_ones)));
    end else if (r < 91) begin
      send_item(CMD_W'($urandom_range(CMD_APPEND, CMD_SPARE_7)), bitv, pos, ord);
    end else begin
      case ($urandom_range(0, 5))
        0: send_item(CMD_ACCESS, bitv, FIELD_W'(vec_len > 0 ? vec_len - 1 : 0), ord);
        1: send_item(CMD_ACCESS, bitv, FIELD_W'(vec_len), ord);
        2: send_item(CMD_RANK, bitv, FIELD_W'(vec_len), ord);
        3: send_item(CMD_RANK, bitv, FIELD_W'(vec_len + 1), ord);
        4: send_item(CMD_SELECT, bitv, pos, FIELD_W'(vec_ones));
        default: send_item(CMD_SELECT, bitv, pos, FIELD_W'(vec_ones + 1));
      endcase
    end
  endtask

  always @(posedge clk) begin : result_check
    answer_t exp_ans;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected result: value %0d status %0d",
                   out_tdata[FIELD_W-1:0], out_tdata[FIELD_W+1:FIELD_W]);
      end else begin
        exp_ans = pending_results.pop_front();
        if (out_tdata[FIELD_W-1:0] !== exp_ans.value ||
            out_tdata[FIELD_W+1:FIELD_W] !== exp_ans.st) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     exp_ans.value, exp_ans.st,
                     out_tdata[FIELD_W-1:0], out_tdata[FIELD_W+1:FIELD_W]);
        end
      end
    end
  end

  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    dir_rows = '{
      '{CMD_RANK,    1'b0, 13'd0,    13'd0,    1'b1, '{13'd0, ST_OK}},
      '{CMD_ACCESS,  1'b0, 13'd0,    13'd0,    1'b1, '{13'd0, ST_RANGE}},
      '{CMD_SELECT,  1'b0, 13'd0,    13'd0,    1'b1, '{13'd0, ST_ABSENT}},
      '{CMD_SELECT,  1'b0, 13'd0,    13'd1,    1'b1, '{13'd0, ST_ABSENT}},
      '{CMD_RANK,    1'b0, 13'd1,    13'd0,    1'b1, '{13'd0, ST_RANGE}},
      '{CMD_APPEND,  1'b1, 13'd8191, 13'd8191, 1'b1, '{13'd0, ST_OK}},
      '{CMD_APPEND,  1'b0, 13'd0,    13'd0,    1'b1, '{13'd0, ST_OK}},
      '{CMD_APPEND,  1'b1, 13'd0,    13'd0,    1'b1, '{13'd0, ST_OK}},
      '{CMD_APPEND,  1'b1, 13'd0,    13'd0,    1'b1, '{13'd0, ST_OK}},
      '{CMD_ACCESS,  1'b0, 13'd0,    13'd0,    1'b0, '0},
      '{CMD_ACCESS,  1'b1, 13'd1,    13'd8191, 1'b0, '0},
      '{CMD_ACCESS,  1'b0, 13'd3,    13'd0,    1'b0, '0},
      '{CMD_ACCESS,  1'b0, 13'd4,    13'd0,    1'b1, '{13'd0, ST_RANGE}},
      '{CMD_ACCESS,  1'b0, 13'd8191, 13'd0,    1'b1, '{13'd0, ST_RANGE}},
      '{CMD_RANK,    1'b0, 13'd4,    13'd0,    1'b0, '0},
      '{CMD_RANK,    1'b0, 13'd5,    13'd0,    1'b1, '{13'd0, ST_RANGE}},
      '{CMD_RANK,    1'b1, 13'd8191, 13'd8191, 1'b1, '{13'd0, ST_RANGE}},
      '{CMD_SELECT,  1'b0, 13'd0,    13'd1,    1'b0, '0},
      '{CMD_SELECT,  1'b0, 13'd8191, 13'd3,    1'b0, '0},
      '{CMD_SELECT,  1'b0, 13'd0,    13'd4,    1'b1, '{13'd0, ST_ABSENT}},
      '{CMD_SELECT,  1'b1, 13'd0,    13'd8191, 1'b1, '{13'd0, ST_ABSENT}},
      '{CMD_SPARE_5, 1'b1, 13'd8191, 13'd8191, 1'b1, '{13'd0, ST_OK}},
      '{CMD_SPARE_6, 1'b0, 13'd4096, 13'd4096, 1'b1, '{13'd0, ST_OK}},
      '{CMD_SPARE_7, 1'b1, 13'd2,    13'd1,    1'b1, '{13'd0, ST_OK}},
      '{CMD_CLEAR,   1'b1, 13'd8191, 13'd8191, 1'b1, '{13'd0, ST_OK}},
      '{CMD_RANK,    1'b0, 13'd0,    13'd0,    1'b1, '{13'd0, ST_OK}}
    };
    vec_len  = 0;
    vec_ones = 0;
    prefix_count[0] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].bitv, dir_rows[i].pos, dir_rows[i].ord,
                dir_rows[i].fixed, dir_rows[i].ans);

    // fill the store to capacity, then probe the top end
    while (vec_len < MAX_BITS)
      send_item(CMD_APPEND, 1'($urandom_range(0, 1)), rand_field(), rand_field());
    send_item(CMD_APPEND, 1'b1, rand_field(), rand_field());
    send_item(CMD_APPEND, 1'b0, rand_field(), rand_field());
    send_item(CMD_ACCESS, 1'b0, FIELD_W'(MAX_BITS - 1), rand_field());
    send_item(CMD_RANK, 1'b0, FIELD_W'(MAX_BITS), rand_field());
    send_item(CMD_RANK, 1'b0, FIELD_W'(MAX_BITS + 1), rand_field());
    send_item(CMD_SELECT, 1'b0, rand_field(), FIELD_W'(vec_ones));
    send_item(CMD_SELECT, 1'b0, rand_field(), FIELD_W'(1));
    send_item(CMD_SELECT, 1'b0, rand_field(), FIELD_W'(vec_ones + 1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 300) >= 240;
      send_random_item();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== bit_vector_rank_select_unit.f =====
+incdir+hdl
hdl/bvrs_pkg.sv
hdl/bvrs_ram.sv
hdl/bvrs_ctrl.sv
hdl/bvrs_dp.sv
hdl/bit_vector_rank_select_unit.sv
bench/bit_vector_rank_select_unit_tb.sv
